>>> rtl/core/pgm_pkg.sv
// Shared types, constants and register codes for the Prewitt gradient magnitude block.
package pgm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int MAX_HEIGHT     = 1024;
  localparam int DIM_W          = 11;
  localparam int ROW_W          = 11;
  localparam int MAG_W          = 11;
  localparam int MAG_MAX        = 2047;
  localparam int DIM_RESET      = 512;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_GRAD,
    S_SQUARE,
    S_ROOT,
    S_EMIT
  } pgm_state_e;

  typedef struct packed {
    logic shift;
    logic grad;
    logic square;
    logic root_step;
    logic out_load;
    logic advance;
    logic restart;
    logic edge_sel;
  } pgm_cmd_t;

  typedef struct packed {
    logic draining;
    logic edge_case;
    logic res_case;
    logic last_row;
    logic root_last;
    logic out_free;
  } pgm_sts_t;

endpackage

>>> rtl/core/pgm_regs.sv
// Configuration register file with an APB-style access port.
module pgm_regs
  import pgm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [DIM_W-1:0]  frame_width_o,
  output logic [DIM_W-1:0]  frame_height_o,
  output logic              cfg_wr_o
);

  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic             wr;

  assign pready   = 1'b1;
  assign wr       = psel & penable & pwrite;
  assign cfg_wr_o = wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(DIM_RESET);
      frame_height_q <= DIM_W'(DIM_RESET);
    end else if (wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  assign frame_width_o  = frame_width_q;
  assign frame_height_o = frame_height_q;

endmodule

>>> rtl/core/pgm_ctrl.sv
// Controller state machine that sequences one word through shift, gradient, square, root and output.
module pgm_ctrl
  import pgm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cmd_i,
  output logic     in_ready_o,
  input  pgm_sts_t sts_i,
  output pgm_cmd_t cmd_o
);

  pgm_state_e state_q, state_d;
  logic       edge_q, edge_d;
  logic       accept;

  assign accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      edge_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      edge_q  <= edge_d;
    end
  end

  always_comb begin
    state_d = state_q;
    edge_d  = edge_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !(!sts_i.draining && cmd_i == CMD_FLUSH)) begin
          if (sts_i.edge_case) begin
            edge_d  = 1'b1;
            state_d = S_GRAD;
          end else begin
            edge_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts_i.res_case) begin
          edge_d  = 1'b0;
          state_d = S_GRAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_GRAD:   state_d = S_SQUARE;
      S_SQUARE: state_d = S_ROOT;
      S_ROOT: begin
        if (sts_i.root_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          if (edge_q && !sts_i.last_row) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.edge_sel = edge_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE:   in_ready_o = 1'b1;
      S_SHIFT: begin
        cmd_o.shift   = 1'b1;
        cmd_o.advance = !sts_i.res_case;
      end
      S_GRAD:   cmd_o.grad      = 1'b1;
      S_SQUARE: cmd_o.square    = 1'b1;
      S_ROOT:   cmd_o.root_step = 1'b1;
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.restart  = edge_q & sts_i.last_row;
          cmd_o.advance  = !edge_q;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pgm_datapath.sv
// Datapath with row store, 3x3 window, gradient, bit-serial square root and output register.
module pgm_datapath
  import pgm_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic [DIM_W-1:0]      frame_width_i,
  input  logic [DIM_W-1:0]      frame_height_i,
  input  logic                  cfg_wr_i,
  input  pgm_cmd_t              cmd_i,
  output pgm_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MAG_W-1:0]      magnitude_o,
  output logic                  last_of_frame_o
);

  localparam int P      = PIXEL_BITS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SW     = P + 2;
  localparam int GW     = P + 3;
  localparam int ROOT_W = P + 3;
  localparam int VW     = 2 * ROOT_W;
  localparam int NW     = $clog2(ROOT_W);

  logic [2*P-1:0]  mem [MAX_WIDTH];
  logic [2*P-1:0]  rd_q;
  logic [P-1:0]    pix_q;
  logic [P-1:0]    win_q [3][3];
  logic [CW-1:0]   c_q;
  logic [ROW_W-1:0] r_q;
  logic [CW:0]     w_eff;
  logic [DIM_W-1:0] h_eff;
  logic            draining;

  logic [ROW_W-1:0] crow;
  logic            top_m, bot_m;
  logic [1:0]      col_l, col_r;
  logic [P-1:0]    p0 [3];
  logic [P-1:0]    p1 [3];
  logic [P-1:0]    p2 [3];
  logic [1:0]      cols [3];
  logic [SW-1:0]   sum_l, sum_r, sum_t, sum_b;
  logic signed [GW-1:0] gx_q, gy_q;
  logic [SW-1:0]   ax, ay;

  logic [VW-1:0]     val_q;
  logic [ROOT_W+1:0] rem_q, rem_sh, trial;
  logic [ROOT_W-1:0] root_q;
  logic [NW-1:0]     cnt_q;
  logic [MAG_W-1:0]  mag;
  logic              out_valid_q, last_q;
  logic [MAG_W-1:0]  mag_q;

  always_comb begin
    if (frame_width_i < DIM_W'(2)) begin
      w_eff = (CW+1)'(2);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width_i);
    end
    if (frame_height_i < DIM_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (frame_height_i > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_i;
    end
  end

  assign draining = r_q >= ROW_W'(h_eff);

  assign sts_o.draining  = draining;
  assign sts_o.edge_case = (c_q == '0) && (r_q >= ROW_W'(2));
  assign sts_o.res_case  = (c_q != '0) && (r_q != '0);
  assign sts_o.last_row  = {1'b0, r_q} == ({1'b0, h_eff} + (ROW_W+1)'(1));
  assign sts_o.root_last = cnt_q == NW'(ROOT_W - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q <= pixel_i;
    end
    if (cmd_i.shift && !draining) begin
      mem[c_q] <= {rd_q[P-1:0], pix_q};
    end
    rd_q <= mem[c_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_q[2*P-1:P];
      win_q[1][2] <= rd_q[P-1:0];
      win_q[2][2] <= draining ? '0 : pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else if (cfg_wr_i || cmd_i.restart) begin
      c_q <= '0;
      r_q <= '0;
    end else if (cmd_i.advance) begin
      if (({1'b0, c_q} + (CW+1)'(1)) >= w_eff) begin
        c_q <= '0;
        r_q <= r_q + ROW_W'(1);
      end else begin
        c_q <= c_q + CW'(1);
      end
    end
  end

  always_comb begin
    crow  = cmd_i.edge_sel ? (r_q - ROW_W'(2)) : (r_q - ROW_W'(1));
    top_m = crow == '0;
    bot_m = crow == (ROW_W'(h_eff) - ROW_W'(1));
    col_l = cmd_i.edge_sel ? 2'd1 : ((c_q == CW'(1)) ? 2'd2 : 2'd0);
    col_r = cmd_i.edge_sel ? 2'd1 : 2'd2;
    cols[0] = col_l;
    cols[1] = cmd_i.edge_sel ? 2'd2 : 2'd1;
    cols[2] = col_r;
    for (int j = 0; j < 3; j++) begin
      p0[j] = top_m ? win_q[2][cols[j]] : win_q[0][cols[j]];
      p1[j] = win_q[1][cols[j]];
      p2[j] = bot_m ? p0[j] : win_q[2][cols[j]];
    end
    sum_l = SW'(p0[0]) + SW'(p1[0]) + SW'(p2[0]);
    sum_r = SW'(p0[2]) + SW'(p1[2]) + SW'(p2[2]);
    sum_t = SW'(p0[0]) + SW'(p0[1]) + SW'(p0[2]);
    sum_b = SW'(p2[0]) + SW'(p2[1]) + SW'(p2[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= $signed(GW'(sum_l)) - $signed(GW'(sum_r));
      gy_q <= $signed(GW'(sum_t)) - $signed(GW'(sum_b));
    end
  end

  assign ax = gx_q[GW-1] ? SW'(-gx_q) : SW'(gx_q);
  assign ay = gy_q[GW-1] ? SW'(-gy_q) : SW'(gy_q);

  assign rem_sh = {rem_q[ROOT_W-1:0], val_q[VW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      val_q  <= VW'((2*SW)'(ax) * (2*SW)'(ax)) + VW'((2*SW)'(ay) * (2*SW)'(ay));
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.root_step) begin
      val_q <= {val_q[VW-3:0], 2'b00};
      cnt_q <= cnt_q + NW'(1);
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign mag = (root_q > ROOT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : root_q[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mag_q  <= mag;
      last_q <= cmd_i.edge_sel & sts_o.last_row;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign last_of_frame_o = last_q;

endmodule

>>> rtl/core/prewitt_gradient_magnitude_top.sv
// Top level of the Prewitt gradient magnitude block.
//
//   channel | valid     | ready     | payload
//   input   | in_valid_i  | in_ready_o  | cmd_i, pixel_i
//   output  | out_valid_o | out_ready_i | magnitude_o, last_of_frame_o
//   config  | psel/penable/pwrite | pready | paddr, pwdata, prdata
//
// A word that yields a result passes through the gradient, square, root and output steps, where the
// bit-serial square root resolves one root bit per cycle; a row-wrap word that closes the
// previous row also yields a result. The block takes no new word until it has finished the
// last one. Reset clears control state and the window; the row store needs no clearing.
// A waiting result in the output register stalls the block only when the next result is ready.
module prewitt_gradient_magnitude_top
  import pgm_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MAG_W-1:0]      magnitude_o,
  output logic                  last_of_frame_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [DIM_W-1:0] frame_width, frame_height;
  logic             cfg_wr;
  pgm_cmd_t         cmd;
  pgm_sts_t         sts;

  pgm_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height),
    .cfg_wr_o       (cfg_wr)
  );

  pgm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .cmd_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  pgm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .accept_i        (in_valid_i & in_ready_o),
    .pixel_i,
    .frame_width_i   (frame_width),
    .frame_height_i  (frame_height),
    .cfg_wr_i        (cfg_wr),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o,
    .out_ready_i,
    .magnitude_o,
    .last_of_frame_o
  );

endmodule

>>> rtl/core/pgm_checker.sv
// Port-level assertion checker for the Prewitt gradient magnitude top level, with its bind.
module pgm_checker
  import pgm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [MAG_W-1:0]  magnitude_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o))
    else $error("output word changed while stalled");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> magnitude_o <= MAG_W'(1082))
    else $error("magnitude beyond its range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i && in_ready_o |=> !(out_valid_o && $changed(magnitude_o)
      && !$past(out_ready_i)))
    else $error("result overwritten while waiting");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=>
      (paddr != $past(paddr)) || (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0])))
    else $error("register read does not return written value");

endmodule

bind prewitt_gradient_magnitude_top pgm_checker u_pgm_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .magnitude_o,
  .psel,
  .penable,
  .pwrite,
  .paddr,
  .pwdata,
  .prdata,
  .pready
);

>>> test/testbench.sv
// Self-checking testbench for the Prewitt gradient magnitude block, driven by directed and random traffic.
module testbench;
  import pgm_pkg::*;

  typedef struct {
    logic            cmd;
    logic [7:0]      pix;
    bit              typed;
    logic [MAG_W-1:0] t_mag;
    logic            t_last;
  } word_t;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic             last;
  } grad_t;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_WAIT = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = CMD_PIXEL;
  logic [7:0] pixel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [MAG_W-1:0] magnitude_o;
  logic last_of_frame_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  prewitt_gradient_magnitude_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state.
  logic [10:0] cfg_w, cfg_h;
  logic [7:0]  row_old [1024];
  logic [7:0]  row_new [1024];
  logic [7:0]  win [3][3];
  int          pos_col, pos_row;

  word_t send_q[$];
  grad_t grad_q[$];
  word_t cur_word;
  int    errors = 0;
  int    mismatches = 0;
  int    random_words = 0;
  bit    took = 1'b0;
  bit    hold_req = 1'b0;
  int    idle_cycles = 0;

  function automatic int used_w();
    return (cfg_w < 2) ? 2 : (cfg_w > 1024) ? 1024 : int'(cfg_w);
  endfunction

  function automatic int used_h();
    return (cfg_h < 2) ? 2 : (cfg_h > 1024) ? 1024 : int'(cfg_h);
  endfunction

  function automatic logic [MAG_W-1:0] prewitt_mag(int l, int m, int r, int crow);
    int p[3][3];
    int cols[3];
    int gx, gy, sq, root;
    cols[0] = l; cols[1] = m; cols[2] = r;
    gx = 0; gy = 0; root = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = win[i][cols[j]];
    if (crow == 0)
      for (int j = 0; j < 3; j++) p[0][j] = p[2][j];
    if (crow == used_h() - 1)
      for (int j = 0; j < 3; j++) p[2][j] = p[0][j];
    for (int i = 0; i < 3; i++) gx += p[i][0] - p[i][2];
    for (int j = 0; j < 3; j++) gy += p[0][j] - p[2][j];
    sq = gx * gx + gy * gy;
    for (int b = 11; b >= 0; b--)
      if ((root | (1 << b)) * (root | (1 << b)) <= sq) root |= 1 << b;
    if (root > MAG_MAX) root = MAG_MAX;
    return root[MAG_W-1:0];
  endfunction

  function automatic void restart_frame();
    pos_col = 0;
    pos_row = 0;
  endfunction

  // Advances the predictor by one accepted word and queues what it yields.
  function automatic void predict_word(word_t w);
    int c, r, wd, ht;
    bit draining;
    logic [7:0] top, mid;
    grad_t g;
    wd = used_w(); ht = used_h();
    c = pos_col; r = pos_row;
    draining = (r >= ht);
    if (c >= wd) c = 0;
    if (!draining && w.cmd == CMD_FLUSH) return;
    if (c == 0 && r >= 2) begin
      g.mag = prewitt_mag(1, 2, 1, r - 2);
      g.last = (r - 2 == ht - 1);
      if (w.typed) begin
        g.mag = w.t_mag;
        g.last = w.t_last;
      end
      grad_q.insert(grad_q.size(), g);
      if (r - 2 == ht - 1) begin
        restart_frame();
        return;
      end
    end
    top = row_old[c];
    mid = row_new[c];
    if (!draining) begin
      row_old[c] = mid;
      row_new[c] = w.pix;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = draining ? 8'd0 : w.pix;
    if (c >= 1 && r >= 1) begin
      g.mag = prewitt_mag((c == 1) ? 2 : 0, 1, 2, r - 1);
      g.last = 1'b0;
      if (w.typed) begin
        g.mag = w.t_mag;
        g.last = w.t_last;
      end
      grad_q.insert(grad_q.size(), g);
    end
    c++;
    if (c >= wd) begin
      c = 0;
      r++;
    end
    pos_col = c;
    pos_row = r;
  endfunction

  // Input monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_word(cur_word);
      took = 1'b1;
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    grad_t g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grad_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: mag=%0d last=%0b",
                                       magnitude_o, last_of_frame_o);
      end else begin
        g = grad_q.pop_front();
        if (magnitude_o !== g.mag || last_of_frame_o !== g.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected mag=%0d last=%0b, got mag=%0d last=%0b",
                     g.mag, g.last, magnitude_o, last_of_frame_o);
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic v;
    v = in_valid_i;
    if (took) begin
      took = 1'b0;
      v = 1'b0;
    end
    if (!v && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (send_q.size() > 0) begin
        cur_word = send_q.pop_front();
        cmd_i <= cur_word.cmd;
        pixel_i <= cur_word.pix;
        v = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i <= v;
  end

  // Receiver: stall pattern is redrawn whenever its counter wraps; long hold-off on request.
  int rx_mode = 0;
  int rx_cnt = 0;
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (rx_cnt == 0) rx_mode = $urandom_range(0, 3);
    rx_cnt = (rx_cnt + 1) % 64;
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 9) < 7);
      2: rdy = (rx_cnt % 8) < 3;
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 1'b0;
    end
    out_ready_i <= rdy;
  end

  task automatic wait_idle();
    while (send_q.size() != 0 || in_valid_i || grad_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_write(logic regsel, logic [10:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {regsel, 2'b00}; pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[10:0] !== value) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("Readback mismatch: expected %0d, got %0d",
                                     value, prdata[10:0]);
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (regsel == REG_FRAME_WIDTH) cfg_w = value;
    else cfg_h = value;
    restart_frame();
  endtask

  task automatic set_size(logic [10:0] w, logic [10:0] h);
    wait_idle();
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
  endtask

  function automatic void push_word(logic cmd, logic [7:0] pix);
    word_t w;
    w.cmd = cmd; w.pix = pix; w.typed = 1'b0; w.t_mag = '0; w.t_last = 1'b0;
    send_q.insert(send_q.size(), w);
  endfunction

  // One frame with random content, optional stray flushes, then the drain words.
  function automatic void push_frame(int noise);
    int wd, ht, style;
    logic [7:0] p;
    wd = used_w(); ht = used_h();
    style = $urandom_range(0, 3);
    for (int i = 0; i < wd * ht; i++) begin
      if ($urandom_range(0, 99) < noise) push_word(CMD_FLUSH, 8'($urandom));
      case (style)
        0: p = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        1: p = 8'(i * 37);
        default: p = 8'($urandom);
      endcase
      push_word(CMD_PIXEL, p);
      random_words++;
    end
    for (int i = 0; i <= wd; i++) push_word(1'($urandom_range(0, 1)), 8'($urandom));
    random_words += wd + 1;
  endfunction

  // Directed 2x2 frame: a stray flush, a flat bright frame, and its drain.
  word_t directed[8] = '{
    '{CMD_FLUSH, 8'h00, 1'b0, 11'd0, 1'b0},
    '{CMD_PIXEL, 8'hFF, 1'b0, 11'd0, 1'b0},
    '{CMD_PIXEL, 8'hFF, 1'b0, 11'd0, 1'b0},
    '{CMD_PIXEL, 8'hFF, 1'b0, 11'd0, 1'b0},
    '{CMD_PIXEL, 8'hFF, 1'b1, 11'd0, 1'b0},
    '{CMD_FLUSH, 8'h00, 1'b1, 11'd0, 1'b0},
    '{CMD_PIXEL, 8'hA5, 1'b1, 11'd0, 1'b0},
    '{CMD_FLUSH, 8'h00, 1'b1, 11'd0, 1'b1}
  };

  initial begin
    cfg_w = DIM_RESET;
    cfg_h = DIM_RESET;
    restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    for (int i = 0; i < 1024; i++) begin
      row_old[i] = '0;
      row_new[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_size(11'd2, 11'd2);
    foreach (directed[i]) send_q.insert(send_q.size(), directed[i]);

    // Checkerboard of the extreme intensities on a 3x3 frame.
    set_size(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) push_word(CMD_PIXEL, (i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 4; i++) push_word(CMD_FLUSH, 8'h00);

    // A size write in the middle of a frame starts a new one.
    set_size(11'd5, 11'd4);
    for (int i = 0; i < 7; i++) push_word(CMD_PIXEL, 8'($urandom));
    set_size(11'd4, 11'd3);
    push_frame(0);

    // Out-of-range sizes clamp to the limits.
    set_size(11'd0, 11'd2047);
    for (int i = 0; i < 12; i++) push_word(CMD_PIXEL, 8'($urandom));
    set_size(11'd3, 11'd1);
    push_frame(2);
    random_words = 0;

    for (int ph = 0; random_words < 750; ph++) begin
      if ($urandom_range(0, 7) == 0) set_size(11'($urandom_range(0, 1)),
                                              11'($urandom_range(0, 3)));
      else set_size(11'($urandom_range(2, 12)), 11'($urandom_range(2, 8)));
      if (ph == 3) begin
        hold_req = 1'b1;
        push_frame(0);
        push_frame(0);
      end else begin
        repeat ($urandom_range(1, 2)) push_frame($urandom_range(0, 10));
      end
    end

    wait_idle();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
